### src/sdtq_pkg.sv
// Shared types, codes and defaults for the sorted deadline timer queue.
package sdtq_pkg;

  localparam int MAX_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;
  localparam int TICK_CAP       = 16;

  localparam int REQ_W    = 2;
  localparam int SLOT_ID_W = 4;
  localparam int IN_TIME_W = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_ADJUST = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_WALK,
    S_REPLY,
    S_TICK,
    S_TICK_NEXT
  } state_t;

  // Operations on the ordered list, always applied at the head or the tail.
  typedef enum logic [1:0] {
    LOP_NONE,
    LOP_ROT,   // move head entry to the tail
    LOP_DROP,  // discard head entry
    LOP_PUSH   // append the request's entry at the tail
  } list_op_t;

  typedef struct packed {
    logic     latch_req;
    logic     load_status;
    status_t  status;
    logic     start_walk;
    logic     walk_ins;
    logic     busy_set;
    logic     busy_clr;
    list_op_t op;
    logic     tick_start;
    logic     fire;
    logic     emit;
    logic     emit_fire;
    logic     emit_last;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic slot_ok;
    logic slot_busy;
    logic head_match;
    logic head_ge;
    logic rem_zero;
    logic ins;
    logic due;
    logic out_free;
  } sts_t;

endpackage

### src/sdtq_ctrl.sv
// Sequencer for the timer queue: request decode, list walk and tick loop.
module sdtq_ctrl import sdtq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   check_err;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Request refused before touching the list
  always_comb begin
    unique case (sts.req)
      REQ_ADD: begin
        check_err = !sts.slot_ok || sts.slot_busy;
      end
      REQ_ADJUST, REQ_DELETE: begin
        check_err = !sts.slot_ok || !sts.slot_busy;
      end
      default: begin
        check_err = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.req == REQ_TICK) state_nxt = S_TICK;
        else if (check_err) state_nxt = S_REPLY;
        else state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.rem_zero) state_nxt = S_REPLY;
      end
      S_REPLY: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_TICK: begin
        state_nxt = sts.due ? S_TICK_NEXT : S_REPLY;
      end
      S_TICK_NEXT: begin
        if (sts.out_free) state_nxt = sts.due ? S_TICK : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready      = 1'b1;
        cmd.latch_req = in_valid;
      end
      S_CHECK: begin
        cmd.load_status = 1'b1;
        cmd.status      = ST_OK;
        unique case (sts.req)
          REQ_TICK: begin
            cmd.tick_start = 1'b1;
          end
          REQ_ADD: begin
            if (!sts.slot_ok) begin
              cmd.status = ST_ABSENT;
            end else if (sts.slot_busy) begin
              cmd.status = ST_BUSY;
            end else begin
              cmd.start_walk = 1'b1;
              cmd.busy_set   = 1'b1;
            end
          end
          REQ_ADJUST: begin
            if (check_err) begin
              cmd.status = ST_ABSENT;
            end else begin
              cmd.start_walk = 1'b1;
            end
          end
          default: begin
            if (check_err) begin
              cmd.status = ST_ABSENT;
            end else begin
              cmd.start_walk = 1'b1;
              cmd.walk_ins   = 1'b1;
              cmd.busy_clr   = 1'b1;
            end
          end
        endcase
      end
      S_WALK: begin
        if (sts.rem_zero) begin
          if (!sts.ins) cmd.op = LOP_PUSH;
        end else if (sts.head_match) begin
          cmd.op = LOP_DROP;
        end else if (!sts.ins && sts.head_ge) begin
          cmd.op = LOP_PUSH;
        end else begin
          cmd.op = LOP_ROT;
        end
      end
      S_REPLY: begin
        cmd.emit      = sts.out_free;
        cmd.emit_last = 1'b1;
      end
      S_TICK: begin
        cmd.fire = sts.due;
      end
      S_TICK_NEXT: begin
        cmd.emit      = sts.out_free;
        cmd.emit_fire = 1'b1;
        cmd.emit_last = !sts.due;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### src/sdtq_datapath.sv
// Request registers, slot busy bits, ordered timer list and result register.
module sdtq_datapath import sdtq_pkg::*; #(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [SLOT_ID_W-1:0] in_slot_id,
  input  logic [IN_TIME_W-1:0] in_expire_time,
  input  logic [IN_TIME_W-1:0] in_now_time,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_expired_valid,
  output logic [SLOT_ID_W-1:0] out_expired_id,
  output logic                 out_last
);

  localparam int SLOT_W = $clog2(MAX_TIMERS);
  // One spare list entry: an adjust may re-enter its timer before the walk
  // reaches and drops the old place, so a full list briefly holds one more.
  localparam int LIST_D = MAX_TIMERS + 1;
  localparam int CNT_W  = $clog2(LIST_D + 1);
  localparam int TICK_W = $clog2(TICK_CAP + 1);

  req_t                 req_r;
  logic [SLOT_ID_W-1:0] slot_r;
  logic [TIME_BITS-1:0] exp_r;
  logic [TIME_BITS-1:0] now_r;

  logic [MAX_TIMERS-1:0] busy_r, busy_nxt;
  logic [SLOT_W-1:0]     id_r [LIST_D];
  logic [SLOT_W-1:0]     id_nxt [LIST_D];
  logic [TIME_BITS-1:0]  tm_r [LIST_D];
  logic [TIME_BITS-1:0]  tm_nxt [LIST_D];
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic                  ins_r, ins_nxt;
  logic [TICK_W-1:0]     fired_r, fired_nxt;
  logic [SLOT_W-1:0]     fire_id_r;
  status_t               stat_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic                  out_ev_r;
  logic [SLOT_ID_W-1:0]  out_id_r;
  logic                  out_last_r;

  logic                  slot_ok;
  logic [SLOT_W-1:0]     slot_idx;
  logic                  pop, push;
  logic [SLOT_W-1:0]     new_id;
  logic [TIME_BITS-1:0]  new_tm;
  logic [CNT_W-1:0]      tail;

  assign slot_ok  = 32'(slot_r) < 32'(MAX_TIMERS);
  assign slot_idx = SLOT_W'(slot_r);

  assign sts.req        = req_r;
  assign sts.slot_ok    = slot_ok;
  assign sts.slot_busy  = slot_ok && busy_r[slot_idx];
  assign sts.head_match = (id_r[0] == slot_idx);
  assign sts.head_ge    = (tm_r[0] >= exp_r);
  assign sts.rem_zero   = (rem_r == '0);
  assign sts.ins        = ins_r;
  assign sts.due        = (cnt_r != '0) && (fired_r < TICK_W'(TICK_CAP)) &&
                          !(now_r < tm_r[0]);
  assign sts.out_free   = !out_valid_r || out_ready;

  // List moves: pop at the head, push at the tail, both for a rotation
  always_comb begin
    pop    = (cmd.op == LOP_ROT) || (cmd.op == LOP_DROP) || cmd.fire;
    push   = (cmd.op == LOP_ROT) || (cmd.op == LOP_PUSH);
    new_id = (cmd.op == LOP_ROT) ? id_r[0] : slot_idx;
    new_tm = (cmd.op == LOP_ROT) ? tm_r[0] : exp_r;
    tail   = pop ? cnt_r - CNT_W'(1) : cnt_r;
    for (int i = 0; i < LIST_D; i++) begin
      id_nxt[i] = id_r[i];
      tm_nxt[i] = tm_r[i];
      if (pop && i < LIST_D - 1) begin
        id_nxt[i] = id_r[i+1];
        tm_nxt[i] = tm_r[i+1];
      end
      if (push && CNT_W'(i) == tail) begin
        id_nxt[i] = new_id;
        tm_nxt[i] = new_tm;
      end
    end
    cnt_nxt = cnt_r;
    if (pop && !push) cnt_nxt = cnt_r - CNT_W'(1);
    else if (push && !pop) cnt_nxt = cnt_r + CNT_W'(1);
  end

  always_comb begin
    busy_nxt = busy_r;
    if (cmd.busy_set) busy_nxt[slot_idx] = 1'b1;
    if (cmd.busy_clr) busy_nxt[slot_idx] = 1'b0;
    if (cmd.fire) busy_nxt[id_r[0]] = 1'b0;

    rem_nxt = rem_r;
    if (cmd.start_walk) rem_nxt = cnt_r;
    else if (cmd.op == LOP_ROT || cmd.op == LOP_DROP) rem_nxt = rem_r - CNT_W'(1);

    ins_nxt = ins_r;
    if (cmd.start_walk) ins_nxt = cmd.walk_ins;
    else if (cmd.op == LOP_PUSH) ins_nxt = 1'b1;

    fired_nxt = fired_r;
    if (cmd.tick_start) fired_nxt = '0;
    else if (cmd.fire) fired_nxt = fired_r + TICK_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= '0;
      cnt_r       <= '0;
      rem_r       <= '0;
      ins_r       <= 1'b0;
      fired_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      ins_r   <= ins_nxt;
      fired_r <= fired_nxt;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LIST_D; i++) begin
      id_r[i] <= id_nxt[i];
      tm_r[i] <= tm_nxt[i];
    end
    if (cmd.latch_req) begin
      req_r  <= req_t'(in_req_type);
      slot_r <= in_slot_id;
      exp_r  <= TIME_BITS'(in_expire_time);
      now_r  <= TIME_BITS'(in_now_time);
    end
    if (cmd.load_status) stat_r <= cmd.status;
    if (cmd.fire) fire_id_r <= id_r[0];
    if (cmd.emit) begin
      out_status_r <= cmd.emit_fire ? ST_OK : stat_r;
      out_ev_r     <= cmd.emit_fire;
      out_id_r     <= cmd.emit_fire ? SLOT_ID_W'(fire_id_r) : '0;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_expired_valid = out_ev_r;
  assign out_expired_id    = out_id_r;
  assign out_last          = out_last_r;

endmodule

### src/sorted_deadline_timer_queue.sv
// Top level of the sorted deadline timer queue: sequencer plus datapath.
//
// Usage: one request beat enters on the in_ channel (valid/ready); each request
// produces one or more result beats on the out_ channel (valid/ready), the final
// one flagged by out_last. Add, adjust and delete give a single beat carrying the
// status; a tick gives one beat per fired timer, earliest first, at most 16 per
// tick, or a single empty beat when nothing is due.
//
// Timing: a request is taken when the sequencer is idle. The ordered list is
// walked by rotating it one entry per cycle past its head, so add, adjust and
// delete take longer as more timers are queued. A tick fires each due timer in
// S_TICK and hands its beat on in S_TICK_NEXT. The walk over the list sets the
// rate; requests are handled one at a time.
//
// Reset (rst_n low, synchronous) frees every slot and empties the list; the
// block is usable on the next cycle, no clearing pass is needed.
// Stall: results sit in an output register; while out_ready is low the
// sequencer holds before the next result beat, and a new request is still taken
// once the previous one has handed its last beat to that register.
module sorted_deadline_timer_queue import sdtq_pkg::*; #(
  parameter int MAX_TIMERS = MAX_TIMERS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [SLOT_ID_W-1:0] in_slot_id,
  input  logic [IN_TIME_W-1:0] in_expire_time,
  input  logic [IN_TIME_W-1:0] in_now_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_expired_valid,
  output logic [SLOT_ID_W-1:0] out_expired_id,
  output logic                 out_last
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: decodes the request, drives the list walk and the tick loop
  sdtq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: slot busy bits, ordered list of (slot, expiry), result register
  sdtq_datapath #(
    .MAX_TIMERS (MAX_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_req_type       (in_req_type),
    .in_slot_id        (in_slot_id),
    .in_expire_time    (in_expire_time),
    .in_now_time       (in_now_time),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_expired_valid (out_expired_valid),
    .out_expired_id    (out_expired_id),
    .out_last          (out_last)
  );

endmodule
